// ----- rtl/arc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and codes for the ARP responder with proxy cache.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b1;

    localparam logic [15:0] OP_REQUEST     = 16'd1;
    localparam logic [15:0] OP_REPLY       = 16'd2;
    localparam logic [15:0] HW_TYPE_ETH    = 16'd1;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEARN
    } state_t;

endpackage

// ----- rtl/arc_cache_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_cache_mem
// Cache entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arc_cache_mem #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  arc_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output arc_pkg::entry_t rdata
);
    import arc_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/arc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_ctrl
// Packet check, cache scan sequencer, learn write and reply register.
// ----------------------------------------------------------------------------
module arc_ctrl #(
    parameter int CACHE_ENTRIES = 16,
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [15:0]             opcode,
    input  logic [15:0]             hw_type,
    input  logic [15:0]             proto_type,
    input  logic [7:0]              hw_len,
    input  logic [7:0]              proto_len,
    input  logic [arc_pkg::MAC_W-1:0] sender_mac,
    input  logic [arc_pkg::IP_W-1:0]  sender_ip,
    input  logic [arc_pkg::IP_W-1:0]  target_ip,
    input  logic [arc_pkg::MAC_W-1:0] own_mac,
    input  logic [arc_pkg::IP_W-1:0]  own_ip,
    output logic                    mem_we,
    output logic [IDX_W-1:0]        mem_waddr,
    output arc_pkg::entry_t         mem_wdata,
    output logic                    mem_re,
    output logic [IDX_W-1:0]        mem_raddr,
    input  arc_pkg::entry_t         mem_rdata,
    output logic                    reply_valid,
    output logic [arc_pkg::MAC_W-1:0] reply_sender_mac,
    output logic [arc_pkg::IP_W-1:0]  reply_sender_ip,
    output logic [arc_pkg::MAC_W-1:0] reply_target_mac,
    output logic [arc_pkg::IP_W-1:0]  reply_target_ip,
    output logic                    answered_from_cache
);
    import arc_pkg::*;

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;

    logic [MAC_W-1:0] pkt_mac_reg;
    logic [IP_W-1:0]  pkt_sip_reg;
    logic [IP_W-1:0]  pkt_tip_reg;

    logic             reply_valid_reg, reply_valid_next;
    logic [MAC_W-1:0] rep_smac_reg, rep_smac_next;
    logic [IP_W-1:0]  rep_sip_reg, rep_sip_next;
    logic [MAC_W-1:0] rep_tmac_reg, rep_tmac_next;
    logic [IP_W-1:0]  rep_tip_reg, rep_tip_next;
    logic             rep_cache_reg, rep_cache_next;

    logic accept;
    logic pkt_ok;
    logic is_req;
    logic own_hit;
    logic scan_go;
    logic has_room;
    logic hit;
    logic last;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign pkt_ok   = (hw_type == HW_TYPE_ETH) && (proto_type == PROTO_IPV4)
                   && (hw_len == HW_LEN_ETH) && (proto_len == PROTO_LEN_IPV4)
                   && ((opcode == OP_REQUEST) || (opcode == OP_REPLY));
    assign is_req   = (opcode == OP_REQUEST);
    assign own_hit  = (target_ip == own_ip);
    assign scan_go  = accept && pkt_ok && is_req && !own_hit && (fill_count_reg != '0);
    assign has_room = (fill_count_reg != CNT_W'(CACHE_ENTRIES));
    assign hit      = (mem_rdata.ip == pkt_tip_reg);
    assign last     = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == fill_count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (scan_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = ST_LEARN;
                end
            end
            ST_LEARN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we           = 1'b0;
        mem_waddr        = fill_count_reg[IDX_W-1:0];
        mem_wdata.ip     = pkt_sip_reg;
        mem_wdata.mac    = pkt_mac_reg;
        mem_re           = 1'b0;
        mem_raddr        = scan_idx_reg + IDX_W'(1);
        scan_idx_next    = scan_idx_reg;
        reply_valid_next = 1'b0;
        rep_smac_next    = rep_smac_reg;
        rep_sip_next     = rep_sip_reg;
        rep_tmac_next    = rep_tmac_reg;
        rep_tip_next     = rep_tip_reg;
        rep_cache_next   = rep_cache_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_idx_next = '0;
                if (accept && pkt_ok)
                begin
                    if (scan_go)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                    end
                    else
                    begin
                        mem_we        = has_room;
                        mem_wdata.ip  = sender_ip;
                        mem_wdata.mac = sender_mac;
                        if (is_req && own_hit)
                        begin
                            reply_valid_next = 1'b1;
                            rep_smac_next    = own_mac;
                            rep_sip_next     = own_ip;
                            rep_tmac_next    = sender_mac;
                            rep_tip_next     = sender_ip;
                            rep_cache_next   = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    reply_valid_next = 1'b1;
                    rep_smac_next    = mem_rdata.mac;
                    rep_sip_next     = mem_rdata.ip;
                    rep_tmac_next    = pkt_mac_reg;
                    rep_tip_next     = pkt_sip_reg;
                    rep_cache_next   = 1'b1;
                end
                else if (!last)
                begin
                    mem_re        = 1'b1;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_LEARN:
            begin
                mem_we = has_room;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign fill_count_next = mem_we ? (fill_count_reg + CNT_W'(1)) : fill_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_count_reg  <= '0;
            scan_idx_reg    <= '0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_count_reg  <= fill_count_next;
            scan_idx_reg    <= scan_idx_next;
            reply_valid_reg <= reply_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pkt_mac_reg <= sender_mac;
            pkt_sip_reg <= sender_ip;
            pkt_tip_reg <= target_ip;
        end
        rep_smac_reg  <= rep_smac_next;
        rep_sip_reg   <= rep_sip_next;
        rep_tmac_reg  <= rep_tmac_next;
        rep_tip_reg   <= rep_tip_next;
        rep_cache_reg <= rep_cache_next;
    end

    assign reply_valid         = reply_valid_reg;
    assign reply_sender_mac    = rep_smac_reg;
    assign reply_sender_ip     = rep_sip_reg;
    assign reply_target_mac    = rep_tmac_reg;
    assign reply_target_ip     = rep_tip_reg;
    assign answered_from_cache = rep_cache_reg;

endmodule

// ----- rtl/arp_responder_with_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP responder that answers for its own address and, from a learned cache,
// as a proxy for other stations.
// ----------------------------------------------------------------------------
// A packet is taken when start is high and busy is low. Dropped packets,
// replies (opcode 2), requests for own_ip and requests that meet an empty
// cache finish in the accepting cycle; a request for another IP with k
// learned entries (k at least one) reads the cache one entry per cycle
// through the single read port; it stays busy through the scan state, which
// ends at entry k or earlier on a match, and then the learn state.
// A reply appears on the reply ports for exactly one cycle with reply_valid
// high, in the cycle after the decision, and the receiver cannot stall it.
// The cache fills in order and is never cleared except by reset, so no
// clearing pass is needed. Write own_mac and own_ip only while busy is low.
// ----------------------------------------------------------------------------
module arp_responder_with_cache #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arc_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [15:0]                   opcode,
    input  logic [15:0]                   hw_type,
    input  logic [15:0]                   proto_type,
    input  logic [7:0]                    hw_len,
    input  logic [7:0]                    proto_len,
    input  logic [arc_pkg::MAC_W-1:0]     sender_mac,
    input  logic [arc_pkg::IP_W-1:0]      sender_ip,
    input  logic [arc_pkg::IP_W-1:0]      target_ip,
    output logic                          reply_valid,
    output logic [arc_pkg::MAC_W-1:0]     reply_sender_mac,
    output logic [arc_pkg::IP_W-1:0]      reply_sender_ip,
    output logic [arc_pkg::MAC_W-1:0]     reply_target_mac,
    output logic [arc_pkg::IP_W-1:0]      reply_target_ip,
    output logic                          answered_from_cache
);
    import arc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [MAC_W-1:0] own_mac_reg;
    logic [IP_W-1:0]  own_ip_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_MAC: own_mac_reg <= cfg_wdata[MAC_W-1:0];
                REG_OWN_IP:  own_ip_reg  <= cfg_wdata[IP_W-1:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    arc_ctrl #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_ctrl (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .opcode              (opcode),
        .hw_type             (hw_type),
        .proto_type          (proto_type),
        .hw_len              (hw_len),
        .proto_len           (proto_len),
        .sender_mac          (sender_mac),
        .sender_ip           (sender_ip),
        .target_ip           (target_ip),
        .own_mac             (own_mac_reg),
        .own_ip              (own_ip_reg),
        .mem_we              (mem_we),
        .mem_waddr           (mem_waddr),
        .mem_wdata           (mem_wdata),
        .mem_re              (mem_re),
        .mem_raddr           (mem_raddr),
        .mem_rdata           (mem_rdata),
        .reply_valid         (reply_valid),
        .reply_sender_mac    (reply_sender_mac),
        .reply_sender_ip     (reply_sender_ip),
        .reply_target_mac    (reply_target_mac),
        .reply_target_ip     (reply_target_ip),
        .answered_from_cache (answered_from_cache)
    );

    arc_cache_mem #(
        .DEPTH(CACHE_ENTRIES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ARP responder with proxy cache. Drives parsed
// packets through the start/busy handshake and writes own_mac and own_ip
// between phases while the block is idle. A tracker class keeps its own copy
// of the addresses and the cache, predicts the reply of each accepted packet
// and compares every reply strobe against the oldest prediction. Stimulus is
// a directed opening followed by random phases of well-formed requests and
// replies mixed with malformed headers and unknown opcodes.
// ----------------------------------------------------------------------------
module tb;

    import arc_pkg::*;

    localparam int CACHE_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [15:0]      opcode;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
    } arp_packet_t;

    typedef struct {
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [MAC_W-1:0] target_mac;
        logic [IP_W-1:0]  target_ip;
        logic             from_cache;
    } arp_reply_t;

    class arp_reply_tracker;
        logic [MAC_W-1:0] own_mac;
        logic [IP_W-1:0]  own_ip;
        bit               cache_valid [CACHE_DEPTH];
        logic [IP_W-1:0]  cache_ip    [CACHE_DEPTH];
        logic [MAC_W-1:0] cache_mac   [CACHE_DEPTH];
        arp_reply_t       pending_replies [$];
        int               mismatches;

        function new();
            own_mac    = '0;
            own_ip     = '0;
            mismatches = 0;
            foreach (cache_valid[i])
            begin
                cache_valid[i] = 1'b0;
                cache_ip[i]    = '0;
                cache_mac[i]   = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == REG_OWN_MAC)
                own_mac = data[MAC_W-1:0];
            else if (idx == REG_OWN_IP)
                own_ip = data[IP_W-1:0];
        endfunction

        function void note_packet(arp_packet_t p);
            arp_reply_t r;
            bit         done;
            int         i;
            if (p.hw_type != HW_TYPE_ETH || p.proto_type != PROTO_IPV4 ||
                p.hw_len != HW_LEN_ETH || p.proto_len != PROTO_LEN_IPV4)
                return;
            if (p.opcode != OP_REQUEST && p.opcode != OP_REPLY)
                return;
            r.target_mac = p.sender_mac;
            r.target_ip  = p.sender_ip;
            if (p.opcode == OP_REQUEST)
            begin
                if (p.target_ip == own_ip)
                begin
                    r.sender_mac = own_mac;
                    r.sender_ip  = own_ip;
                    r.from_cache = 1'b0;
                    pending_replies.push_back(r);
                end
                else
                begin
                    done = 1'b0;
                    for (i = 0; i < CACHE_DEPTH; i++)
                    begin
                        if (!done && cache_valid[i] && cache_ip[i] == p.target_ip)
                        begin
                            r.sender_mac = cache_mac[i];
                            r.sender_ip  = cache_ip[i];
                            r.from_cache = 1'b1;
                            pending_replies.push_back(r);
                            done = 1'b1;
                        end
                    end
                end
            end
            done = 1'b0;
            for (i = 0; i < CACHE_DEPTH; i++)
            begin
                if (!done && !cache_valid[i])
                begin
                    cache_valid[i] = 1'b1;
                    cache_ip[i]    = p.sender_ip;
                    cache_mac[i]   = p.sender_mac;
                    done           = 1'b1;
                end
            end
        endfunction

        function void check_reply(arp_reply_t got);
            arp_reply_t exp;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected reply smac %h sip %h tmac %h tip %h cache %b",
                             $realtime, got.sender_mac, got.sender_ip, got.target_mac,
                             got.target_ip, got.from_cache);
                return;
            end
            exp = pending_replies.pop_front();
            if (got.sender_mac !== exp.sender_mac || got.sender_ip !== exp.sender_ip ||
                got.target_mac !== exp.target_mac || got.target_ip !== exp.target_ip ||
                got.from_cache !== exp.from_cache)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: reply wrong", $realtime);
                    $display("  expected smac %h sip %h tmac %h tip %h cache %b",
                             exp.sender_mac, exp.sender_ip, exp.target_mac,
                             exp.target_ip, exp.from_cache);
                    $display("  actual   smac %h sip %h tmac %h tip %h cache %b",
                             got.sender_mac, got.sender_ip, got.target_mac,
                             got.target_ip, got.from_cache);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;
    logic                 start;
    logic                 busy;
    logic [15:0]          opcode;
    logic [15:0]          hw_type;
    logic [15:0]          proto_type;
    logic [7:0]           hw_len;
    logic [7:0]           proto_len;
    logic [MAC_W-1:0]     sender_mac;
    logic [IP_W-1:0]      sender_ip;
    logic [IP_W-1:0]      target_ip;
    logic                 reply_valid;
    logic [MAC_W-1:0]     reply_sender_mac;
    logic [IP_W-1:0]      reply_sender_ip;
    logic [MAC_W-1:0]     reply_target_mac;
    logic [IP_W-1:0]      reply_target_ip;
    logic                 answered_from_cache;

    arp_reply_tracker tracker;
    arp_reply_t       seen_reply;
    int               quiet_cycles;
    logic [IP_W-1:0]  ip_pool [32];

    arp_responder_with_cache #(
        .CACHE_ENTRIES(CACHE_DEPTH)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .start               (start),
        .busy                (busy),
        .opcode              (opcode),
        .hw_type             (hw_type),
        .proto_type          (proto_type),
        .hw_len              (hw_len),
        .proto_len           (proto_len),
        .sender_mac          (sender_mac),
        .sender_ip           (sender_ip),
        .target_ip           (target_ip),
        .reply_valid         (reply_valid),
        .reply_sender_mac    (reply_sender_mac),
        .reply_sender_ip     (reply_sender_ip),
        .reply_target_mac    (reply_target_mac),
        .reply_target_ip     (reply_target_ip),
        .answered_from_cache (answered_from_cache)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (reply_valid)
            begin
                seen_reply.sender_mac = reply_sender_mac;
                seen_reply.sender_ip  = reply_sender_ip;
                seen_reply.target_mac = reply_target_mac;
                seen_reply.target_ip  = reply_target_ip;
                seen_reply.from_cache = answered_from_cache;
                tracker.check_reply(seen_reply);
            end
            if (reply_valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    function automatic arp_packet_t make_packet(logic [15:0] op, logic [MAC_W-1:0] smac,
                                                logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
        arp_packet_t p;
        p.opcode     = op;
        p.hw_type    = HW_TYPE_ETH;
        p.proto_type = PROTO_IPV4;
        p.hw_len     = HW_LEN_ETH;
        p.proto_len  = PROTO_LEN_IPV4;
        p.sender_mac = smac;
        p.sender_ip  = sip;
        p.target_ip  = tip;
        return p;
    endfunction

    function automatic arp_packet_t random_packet();
        arp_packet_t p;
        int          roll;
        int          pick;
        logic [IP_W-1:0] sip;
        logic [IP_W-1:0] tip;
        roll = $urandom_range(99);
        sip  = ($urandom_range(1) == 1) ? ip_pool[$urandom_range(31)] : $urandom;
        pick = $urandom_range(99);
        if (pick < 25)
            tip = tracker.own_ip;
        else if (pick < 70)
            tip = tracker.cache_ip[$urandom_range(CACHE_DEPTH-1)];
        else if (pick < 80)
            tip = sip;
        else if (pick < 90)
            tip = ip_pool[$urandom_range(31)];
        else
            tip = $urandom;
        p = make_packet(($urandom_range(99) < 70) ? OP_REQUEST : OP_REPLY,
                        rand_mac(), sip, tip);
        if (roll < 8)
        begin
            p.opcode     = 16'($urandom);
            p.hw_type    = 16'($urandom);
            p.proto_type = 16'($urandom);
            p.hw_len     = 8'($urandom);
            p.proto_len  = 8'($urandom);
        end
        else if (roll < 18)
        begin
            case ($urandom_range(3))
                0:       p.hw_type    = 16'($urandom);
                1:       p.proto_type = 16'($urandom);
                2:       p.hw_len     = 8'($urandom);
                default: p.proto_len  = 8'($urandom);
            endcase
        end
        else if (roll < 22)
            p.opcode = 16'($urandom);
        return p;
    endfunction

    task automatic send_packet(input arp_packet_t p, input bit allow_gap);
        @(negedge clk);
        if (allow_gap && $urandom_range(99) < 21)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        opcode     = p.opcode;
        hw_type    = p.hw_type;
        proto_type = p.proto_type;
        hw_len     = p.hw_len;
        proto_len  = p.proto_len;
        sender_mac = p.sender_mac;
        sender_ip  = p.sender_ip;
        target_ip  = p.target_ip;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        tracker.note_packet(p);
    endtask

    task automatic drain_replies();
        @(negedge clk);
        start = 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (CACHE_DEPTH + 4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.write_reg(idx, data);
    endtask

    initial
    begin
        arp_packet_t p;
        int          phase_items [4];
        int          ph;
        int          k;
        tracker      = new();
        quiet_cycles = 0;
        phase_items  = '{240, 240, 240, 230};
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        start        = 1'b0;
        opcode       = '0;
        hw_type      = '0;
        proto_type   = '0;
        hw_len       = '0;
        proto_len    = '0;
        sender_mac   = '0;
        sender_ip    = '0;
        target_ip    = '0;
        foreach (ip_pool[i])
            ip_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_OWN_MAC, {MAC_W{1'b1}});
        write_reg(REG_OWN_IP, {CFG_DAT_W{1'b1}});

        send_packet(make_packet(OP_REQUEST, '0, '0, {IP_W{1'b1}}), 1'b0);
        send_packet(make_packet(OP_REQUEST, {MAC_W{1'b1}}, {IP_W{1'b1}}, '0), 1'b0);
        send_packet(make_packet(OP_REQUEST, 48'h0200_0000_0003, 32'h0A00_0003,
                                {IP_W{1'b1}}), 1'b1);
        send_packet(make_packet(OP_REQUEST, 48'h0200_0000_0005, 32'h0A00_0005,
                                32'h0A00_0005), 1'b1);
        send_packet(make_packet(OP_REPLY, 48'h0200_0000_0006, 32'h0A00_0006,
                                {IP_W{1'b1}}), 1'b1);
        send_packet(make_packet(OP_REQUEST, 48'h0200_0000_0007, 32'h0A00_0007,
                                32'h0A00_0006), 1'b1);
        send_packet(make_packet(OP_REPLY, 48'h0200_0000_0066, 32'h0A00_0006, '0), 1'b1);
        send_packet(make_packet(OP_REQUEST, 48'h0200_0000_0008, 32'h0A00_0008,
                                32'h0A00_0006), 1'b1);

        p = make_packet(OP_REQUEST, 48'h0200_0000_0009, 32'h0A00_0009, {IP_W{1'b1}});
        p.hw_type = 16'h0000;
        send_packet(p, 1'b1);
        p.hw_type = 16'hFFFF;
        send_packet(p, 1'b1);
        p.hw_type = HW_TYPE_ETH;
        p.proto_type = 16'h0806;
        send_packet(p, 1'b1);
        p.proto_type = 16'hFFFF;
        send_packet(p, 1'b1);
        p.proto_type = PROTO_IPV4;
        p.hw_len = 8'h00;
        send_packet(p, 1'b1);
        p.hw_len = 8'hFF;
        send_packet(p, 1'b1);
        p.hw_len = HW_LEN_ETH;
        p.proto_len = 8'h00;
        send_packet(p, 1'b1);
        p.proto_len = 8'hFF;
        send_packet(p, 1'b1);
        p.proto_len = PROTO_LEN_IPV4;
        p.opcode = 16'h0000;
        send_packet(p, 1'b1);
        p.opcode = 16'h0003;
        send_packet(p, 1'b1);
        p.opcode = 16'hFFFF;
        send_packet(p, 1'b1);
        send_packet(make_packet(OP_REQUEST, 48'h0200_0000_000A, 32'h0A00_000A,
                                32'h0A00_0009), 1'b1);
        drain_replies();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_OWN_MAC, rand_mac());
                    write_reg(REG_OWN_IP, rand_mac());
                end
                1:
                begin
                    write_reg(REG_OWN_MAC, '0);
                    write_reg(REG_OWN_IP, {16'hFFFF, 32'h0});
                end
                2:
                begin
                    write_reg(REG_OWN_MAC, {MAC_W{1'b1}});
                    write_reg(REG_OWN_IP, {16'h0, tracker.cache_ip[$urandom_range(CACHE_DEPTH-1)]});
                end
                default:
                begin
                    write_reg(REG_OWN_MAC, rand_mac());
                    write_reg(REG_OWN_IP, {16'h0, {IP_W{1'b1}}});
                end
            endcase
            for (k = 0; k < phase_items[ph]; k++)
            begin
                send_packet(random_packet(), !(ph == 1 && k >= 40 && k < 200));
                if (k == 120)
                    drain_replies();
            end
            drain_replies();
        end

        if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/arc_pkg.sv
rtl/arc_cache_mem.sv
rtl/arc_ctrl.sv
rtl/arp_responder_with_cache.sv
bench/tb.sv
